>>> rtl/qrs_pkg.sv
// Shared widths, result kinds and side-band types for the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

	localparam int CW = 16;
	localparam int RF = 16;
	localparam int DW = 2 * CW + 1;
	localparam int SW = (DW + 2 * RF + 1) / 2;
	localparam int XW = 2 * SW;
	localparam int NW = ((CW + RF > SW) ? CW + RF : SW) + 1;
	localparam int MW = NW + 7;
	localparam int QW = MW - RF - 1;
	localparam int VW = 24;

	localparam logic [VW-1:0] VLIM = 24'd6000000;

	typedef enum logic [1:0] {
		KIND_REAL   = 2'd0,
		KIND_CPLX   = 2'd1,
		KIND_DOUBLE = 2'd2,
		KIND_AZERO  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t         kind;
		logic          an;
		logic [CW-1:0] am;
		logic          nbn;
		logic [CW-1:0] bm;
	} side_t;

endpackage

>>> rtl/qrs_front.sv
// Front end: coefficient magnitudes, products and the discriminant, two stages.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vin,
	input  logic signed [qrs_pkg::CW-1:0]     a,
	input  logic signed [qrs_pkg::CW-1:0]     b,
	input  logic signed [qrs_pkg::CW-1:0]     c,
	output logic                              vout,
	output qrs_pkg::side_t                    side,
	output logic        [qrs_pkg::DW-1:0]     dm
);
	import qrs_pkg::*;

	logic [CW-1:0]     am, bm, cm;
	logic              v_s1, an_s1, nbn_s1, acn_s1, az_s1;
	logic [CW-1:0]     am_s1, bm_s1;
	logic [2*CW-1:0]   b2_s1, ac_s1;
	logic [2*CW+1:0]   b2x, ac4, sum;
	logic              dn;
	kind_t             kind;

	always_comb begin
		am = a[CW-1] ? CW'(~a + 1'b1) : a;
		bm = b[CW-1] ? CW'(~b + 1'b1) : b;
		cm = c[CW-1] ? CW'(~c + 1'b1) : c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1  <= a[CW-1];
			am_s1  <= am;
			bm_s1  <= bm;
			nbn_s1 <= !b[CW-1] && (bm != '0);
			acn_s1 <= a[CW-1] == c[CW-1];
			az_s1  <= am == '0;
			b2_s1  <= bm * bm;
			ac_s1  <= am * cm;
		end
	end

	always_comb begin
		b2x = (2*CW+2)'(b2_s1);
		ac4 = {ac_s1, 2'b00};
		dn  = 1'b0;
		if (!acn_s1) begin
			sum = b2x + ac4;
		end else if (b2x >= ac4) begin
			sum = b2x - ac4;
		end else begin
			sum = ac4 - b2x;
			dn  = 1'b1;
		end
		if (az_s1)
			kind = KIND_AZERO;
		else if (sum == '0)
			kind = KIND_DOUBLE;
		else if (dn)
			kind = KIND_CPLX;
		else
			kind = KIND_REAL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm        <= sum[DW-1:0];
			side.kind <= kind;
			side.an   <= an_s1;
			side.am   <= am_s1;
			side.nbn  <= nbn_s1;
			side.bm   <= bm_s1;
		end
	end

endmodule

>>> rtl/qrs_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  qrs_pkg::side_t                side_in,
	input  logic [qrs_pkg::DW-1:0]        dm,
	output logic                          vout,
	output qrs_pkg::side_t                side_out,
	output logic [qrs_pkg::SW-1:0]        root
);
	import qrs_pkg::*;

	logic           v_s    [0:SW];
	side_t          side_s [0:SW];
	logic [XW-1:0]  x_s    [0:SW];
	logic [SW+1:0]  rem_s  [0:SW];
	logic [SW-1:0]  root_s [0:SW];

	always_comb begin
		v_s[0]    = vin;
		side_s[0] = side_in;
		x_s[0]    = XW'({dm, {(2*RF){1'b0}}});
		rem_s[0]  = '0;
		root_s[0] = '0;
	end

	for (genvar k = 0; k < SW; k++) begin : g_st
		logic [SW+1:0] r_sh, trial;

		always_comb begin
			r_sh  = {rem_s[k][SW-1:0], x_s[k][XW-1 -: 2]};
			trial = {root_s[k], 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				x_s[k+1]    <= {x_s[k][XW-3:0], 2'b00};
				if (r_sh >= trial) begin
					rem_s[k+1]  <= r_sh - trial;
					root_s[k+1] <= {root_s[k][SW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= r_sh;
					root_s[k+1] <= {root_s[k][SW-2:0], 1'b0};
				end
			end
		end
	end

	assign vout     = v_s[SW];
	assign side_out = side_s[SW];
	assign root     = root_s[SW];

endmodule

>>> rtl/qrs_div.sv
// Pipelined restoring divider with ceiling, saturation and sign, one quotient bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  qrs_pkg::kind_t                tag_in,
	input  logic                          neg,
	input  logic                          sticky,
	input  logic [qrs_pkg::QW-1:0]        q0,
	input  logic [qrs_pkg::CW-1:0]        d,
	output logic                          vout,
	output qrs_pkg::kind_t                tag_out,
	output logic [qrs_pkg::VW-1:0]        value
);
	import qrs_pkg::*;

	logic           v_s   [0:QW];
	kind_t          tag_s [0:QW];
	logic           neg_s [0:QW];
	logic           stk_s [0:QW];
	logic [CW-1:0]  d_s   [0:QW];
	logic [QW-1:0]  dvd_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic [CW-1:0]  rem_s [0:QW];
	logic           inc;
	logic [QW:0]    q;
	logic [VW-1:0]  qs;

	always_comb begin
		v_s[0]   = vin;
		tag_s[0] = tag_in;
		neg_s[0] = neg;
		stk_s[0] = sticky;
		d_s[0]   = d;
		dvd_s[0] = q0;
		quo_s[0] = '0;
		rem_s[0] = '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [CW:0] r;

		assign r = {rem_s[k], dvd_s[k][QW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				neg_s[k+1] <= neg_s[k];
				stk_s[k+1] <= stk_s[k];
				d_s[k+1]   <= d_s[k];
				dvd_s[k+1] <= {dvd_s[k][QW-2:0], 1'b0};
				if (r >= {1'b0, d_s[k]}) begin
					rem_s[k+1] <= CW'(r - {1'b0, d_s[k]});
					quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= r[CW-1:0];
					quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		inc = !neg_s[QW] && (stk_s[QW] || (rem_s[QW] != '0));
		q   = {1'b0, quo_s[QW]} + (QW+1)'(inc);
		qs  = (q > (QW+1)'(VLIM)) ? VLIM : VW'(q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else if (en)
			vout <= v_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_out <= tag_s[QW];
			if (d_s[QW] == '0)
				value <= '0;
			else if (neg_s[QW])
				value <= VW'(~qs + 1'b1);
			else
				value <= qs;
		end
	end

endmodule

>>> rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, square root, numerators, dividers.
// Depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div.
//
// Input stream: one word per coefficient set, tdata = {c, b, a}, 16-bit two's complement each.
// Output stream: one word per input word, in order; tuser carries the root kind
// (real pair, complex pair, double root, a is zero), tdata the two values in hundredths,
// each rounded toward plus infinity.
// The square-root and divider pipelines set the depth: two front stages, 33 square-root
// stages (one root bit each), a numerator stage, a scaling stage, 24 divider stages
// (one quotient bit each) and the output register.
// Throughput is one word per cycle unless the receiver stalls the pipeline.
// When the receiver holds tready low with a word waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the output stream is empty afterward.
`timescale 1ns / 1ps

module quadratic_root_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // coef_a, coef_b, coef_c
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // first_value, second_value
	output logic [1:0]  m_axis_tuser    // root_kind
);
	import qrs_pkg::*;

	logic           en;
	logic           v_f, v_r;
	side_t          side_f, side_r;
	logic [DW-1:0]  dm;
	logic [SW-1:0]  root;
	logic [NW-1:0]  nb, s;
	logic [NW-1:0]  n1, n2;
	logic           n1n, n2n;

	logic           v_s3, n1n_s3, n2n_s3, an_s3;
	logic [NW-1:0]  n1_s3, n2_s3;
	logic [CW-1:0]  am_s3;
	kind_t          kind_s3;
	logic [MW-1:0]  m1, m2;

	logic           v_s4, neg1_s4, neg2_s4, stk1_s4, stk2_s4;
	logic [QW-1:0]  q1_s4, q2_s4;
	logic [CW-1:0]  am_s4;
	kind_t          kind_s4, kind_out;
	logic [VW-1:0]  first_value, second_value;

	assign en            = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;

	qrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (s_axis_tvalid),
		.a      (s_axis_tdata[15:0]),
		.b      (s_axis_tdata[31:16]),
		.c      (s_axis_tdata[47:32]),
		.vout   (v_f),
		.side   (side_f),
		.dm     (dm)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_f),
		.side_in  (side_f),
		.dm       (dm),
		.vout     (v_r),
		.side_out (side_r),
		.root     (root)
	);

	always_comb begin
		nb = NW'({side_r.bm, {RF{1'b0}}});
		s  = NW'(root);
		if (side_r.kind == KIND_CPLX) begin
			n1  = nb;
			n1n = side_r.nbn;
			n2  = s;
			n2n = 1'b0;
		end else if (!side_r.nbn) begin
			n1n = 1'b0;
			n1  = nb + s;
			if (nb >= s) begin
				n2  = nb - s;
				n2n = 1'b0;
			end else begin
				n2  = s - nb;
				n2n = 1'b1;
			end
		end else begin
			n2  = nb + s;
			n2n = 1'b1;
			if (nb >= s) begin
				n1  = nb - s;
				n1n = 1'b1;
			end else begin
				n1  = s - nb;
				n1n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_r;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3   <= n1;
			n2_s3   <= n2;
			n1n_s3  <= n1n;
			n2n_s3  <= n2n;
			an_s3   <= side_r.an;
			am_s3   <= side_r.am;
			kind_s3 <= side_r.kind;
		end
	end

	always_comb begin
		m1 = MW'(n1_s3) * MW'(7'd100);
		m2 = MW'(n2_s3) * MW'(7'd100);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s4   <= m1[MW-1:RF+1];
			q2_s4   <= m2[MW-1:RF+1];
			stk1_s4 <= |m1[RF:0];
			stk2_s4 <= |m2[RF:0];
			neg1_s4 <= n1n_s3 ^ an_s3;
			neg2_s4 <= n2n_s3 ^ an_s3;
			am_s4   <= am_s3;
			kind_s4 <= kind_s3;
		end
	end

	qrs_div u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vin     (v_s4),
		.tag_in  (kind_s4),
		.neg     (neg1_s4),
		.sticky  (stk1_s4),
		.q0      (q1_s4),
		.d       (am_s4),
		.vout    (m_axis_tvalid),
		.tag_out (kind_out),
		.value   (first_value)
	);

	qrs_div u_div2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vin     (v_s4),
		.tag_in  (kind_s4),
		.neg     (neg2_s4),
		.sticky  (stk2_s4),
		.q0      (q2_s4),
		.d       (am_s4),
		.vout    (),
		.tag_out (),
		.value   (second_value)
	);

	assign m_axis_tdata = {second_value, first_value};
	assign m_axis_tuser = kind_out;

endmodule
